[sv/pcxrle_pkg.sv]
// ----------------------------------------------------------------------------
// pcxrle_pkg
// shared constants and types of the pcx bitplane run-length decoder
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int DEF_MAX_LINE_BYTES = 4096;
  localparam int DEF_MAX_ROWS       = 65536;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam int RUN_W       = 6;
  localparam int LINE_REG_W  = 13;
  localparam int ROWS_REG_W  = 17;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int LINE_CMP_W  = 17;
  localparam int ROW_CMP_W   = 18;

  localparam logic [1:0] HDR_TAG = 2'b11;

  localparam logic [LINE_REG_W-1:0] RST_LINE_BYTES = LINE_REG_W'(80);
  localparam logic [LINE_REG_W-1:0] RST_KEPT_BYTES = LINE_REG_W'(80);
  localparam logic [ROWS_REG_W-1:0] RST_IMAGE_ROWS = ROWS_REG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_BYTES = 2'd0,
    REG_KEPT_BYTES = 2'd1,
    REG_IMAGE_ROWS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]       value;
    logic [RUN_W-1:0] reps;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel_bits;
    logic       row_end;
    logic       image_end;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [LINE_REG_W-1:0] line_bytes;
    logic [LINE_REG_W-1:0] kept_bytes;
    logic [ROWS_REG_W-1:0] image_rows;
  } cfg_t;

endpackage

[sv/pcxrle_fifo.sv]
// ----------------------------------------------------------------------------
// pcxrle_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module pcxrle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/pcxrle_front.sv]
// ----------------------------------------------------------------------------
// pcxrle_front
// takes compressed bytes, splits run headers from values and literals,
// and queues one (value, repeat) command per byte that yields output
// ----------------------------------------------------------------------------
module pcxrle_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        code_byte,
  output logic              full,
  output logic              cmd_push,
  output pcxrle_pkg::cmd_t  cmd_data,
  input  logic              cmd_full
);

  import pcxrle_pkg::*;

  logic             await_value;
  logic [RUN_W-1:0] run_count;
  logic             accept;
  logic             is_header;

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign is_header = (code_byte[7:6] == HDR_TAG);

  // zero-length runs are dropped here
  assign cmd_push       = accept && (await_value ? (run_count != '0) : !is_header);
  assign cmd_data.value = code_byte;
  assign cmd_data.reps  = await_value ? run_count : RUN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      await_value <= 1'b0;
      run_count   <= '0;
    end else if (accept) begin
      if (await_value) begin
        await_value <= 1'b0;
        run_count   <= '0;
      end else if (is_header) begin
        await_value <= 1'b1;
        run_count   <= code_byte[RUN_W-1:0];
      end
    end
  end

endmodule

[sv/pcxrle_back.sv]
// ----------------------------------------------------------------------------
// pcxrle_back
// expands commands one byte per cycle while the result side is not full,
// tracks line position and row, drops padding and holds one kept byte back
// to mark the last of a command
module pcxrle_back #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES,
  parameter int MAX_ROWS       = pcxrle_pkg::DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  pcxrle_pkg::cfg_t  cfg,
  input  logic              cmd_valid,
  input  pcxrle_pkg::cmd_t  cmd_data,
  output logic              cmd_pop,
  output logic              res_push,
  output pcxrle_pkg::res_t  res_data,
  input  logic              res_full
);

  import pcxrle_pkg::*;

  localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic                  busy;
  logic [7:0]            value;
  logic [RUN_W-1:0]      remain;
  logic [POS_W-1:0]      line_position;
  logic [ROW_W-1:0]      row_index;

  logic                  held_v;
  logic                  held_final;
  logic [7:0]            held_bits;
  logic                  held_row_end;
  logic                  held_image_end;

  logic [7:0]            cur_value;
  logic [RUN_W-1:0]      cur_reps;
  logic                  cur_valid;
  logic                  step;
  logic                  fin;
  logic                  held_go;

  logic [LINE_CMP_W-1:0] lb;
  logic [LINE_CMP_W-1:0] kb;
  logic [LINE_CMP_W-1:0] eff_line;
  logic [LINE_CMP_W-1:0] eff_kept;
  logic [ROW_CMP_W-1:0]  rb;
  logic [ROW_CMP_W-1:0]  eff_rows;
  logic [LINE_CMP_W-1:0] pos_ext;
  logic [LINE_CMP_W-1:0] pos_inc;
  logic [ROW_CMP_W-1:0]  row_inc;
  logic                  keep;
  logic                  k_row_end;
  logic                  k_image_end;
  logic                  last_row;
  logic                  line_wrap;

  // effective register values
  always_comb begin
    lb = LINE_CMP_W'(cfg.line_bytes);
    kb = LINE_CMP_W'(cfg.kept_bytes);
    rb = ROW_CMP_W'(cfg.image_rows);
    priority if (lb == '0) eff_line = LINE_CMP_W'(1);
    else if (lb > LINE_CMP_W'(MAX_LINE_BYTES)) eff_line = LINE_CMP_W'(MAX_LINE_BYTES);
    else eff_line = lb;
    priority if (kb == '0) eff_kept = LINE_CMP_W'(1);
    else if (kb > eff_line) eff_kept = eff_line;
    else eff_kept = kb;
    priority if (rb == '0) eff_rows = ROW_CMP_W'(1);
    else if (rb > ROW_CMP_W'(MAX_ROWS)) eff_rows = ROW_CMP_W'(MAX_ROWS);
    else eff_rows = rb;
  end

  assign cur_value = busy ? value : cmd_data.value;
  assign cur_reps  = busy ? remain : cmd_data.reps;
  assign cur_valid = busy || cmd_valid;
  assign step      = cur_valid && !res_full;
  assign cmd_pop   = step && !busy;
  assign fin       = (cur_reps == RUN_W'(1));

  assign pos_ext     = LINE_CMP_W'(line_position);
  assign pos_inc     = pos_ext + LINE_CMP_W'(1);
  assign row_inc     = ROW_CMP_W'(row_index) + ROW_CMP_W'(1);
  assign keep        = (pos_ext < eff_kept);
  assign k_row_end   = keep && (pos_inc == eff_kept);
  assign last_row    = (row_inc >= eff_rows);
  assign k_image_end = k_row_end && last_row;
  assign line_wrap   = (pos_inc >= eff_line);

  // held byte leaves when its command is done or a newer kept byte arrives
  assign held_go = held_v && !res_full && (held_final || (step && keep));

  assign res_push            = held_go;
  assign res_data.pixel_bits = held_bits;
  assign res_data.row_end    = held_row_end;
  assign res_data.image_end  = held_image_end;
  assign res_data.last       = held_final;

  always_ff @(posedge clk) begin
    if (step) begin
      value  <= cur_value;
      remain <= cur_reps - RUN_W'(1);
    end
    if (step && keep) begin
      held_bits      <= cur_value;
      held_row_end   <= k_row_end;
      held_image_end <= k_image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      held_v        <= 1'b0;
      held_final    <= 1'b0;
      line_position <= '0;
      row_index     <= '0;
    end else begin
      if (step) begin
        busy <= !fin;
        if (line_wrap) begin
          line_position <= '0;
          row_index     <= last_row ? '0 : ROW_W'(row_inc);
        end else begin
          line_position <= POS_W'(pos_inc);
        end
      end
      priority if (step && keep) begin
        held_v     <= 1'b1;
        held_final <= fin;
      end else if (held_go) begin
        held_v     <= 1'b0;
        held_final <= 1'b0;
      end else if (step && fin && held_v) begin
        held_final <= 1'b1;
      end
    end
  end

endmodule

[sv/pcx_rle_bitplane_decoder.sv]
// ----------------------------------------------------------------------------
// pcx_rle_bitplane_decoder
// run-length decoder for 1-bit pcx scanlines with padding removal
// ----------------------------------------------------------------------------
// input side: a queue write port; a byte transfers when push is high and
// full is low. result side: a queue read port; the oldest result sits on
// pixel_bits, row_end, image_end and last while empty is low and transfers
// when pop is high. registers line_bytes, kept_bytes and image_rows are
// written through cfg_we, cfg_idx and cfg_data; the user must write them
// only while the decoder is idle, which the block itself does not enforce.
// literal bytes are taken one per cycle while the command queue has room;
// a run value expands into one decoded byte per cycle in the back end while
// the result queue has room, and the command queue (four entries) keeps
// taking input until it fills. the back end holds each kept byte back to
// learn whether it is the last kept byte of its command.
// reset clears the queues, the run state, line position and row count and
// loads the register defaults 80, 80 and 480.
// when the receiver stalls, the two-entry result queue fills, the back end
// stops, and full rises once the command queue is full.
// ----------------------------------------------------------------------------
module pcx_rle_bitplane_decoder #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES,
  parameter int MAX_ROWS       = pcxrle_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [7:0]                       code_byte,
  output logic                             full,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       pixel_bits,
  output logic                             row_end,
  output logic                             image_end,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0] cfg_data
);

  import pcxrle_pkg::*;

  cfg_t cfg;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_bytes <= RST_LINE_BYTES;
      cfg.kept_bytes <= RST_KEPT_BYTES;
      cfg.image_rows <= RST_IMAGE_ROWS;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_LINE_BYTES: cfg.line_bytes <= cfg_data[LINE_REG_W-1:0];
        REG_KEPT_BYTES: cfg.kept_bytes <= cfg_data[LINE_REG_W-1:0];
        REG_IMAGE_ROWS: cfg.image_rows <= cfg_data[ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  pcxrle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .code_byte (code_byte),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  pcxrle_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  pcxrle_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_ROWS       (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  pcxrle_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign pixel_bits = res_out.pixel_bits;
  assign row_end    = res_out.row_end;
  assign image_end  = res_out.image_end;
  assign last       = res_out.last;

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_image_end_row: assert property (@(posedge clk) disable iff (rst)
    (!empty |-> (!image_end || row_end)))
    else $error("image end without row end");

  a_cmd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && !cmd_full |-> (cmd_in.reps != '0)))
    else $error("zero-length command queued");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (res_push |-> !res_full))
    else $error("result transfer into full queue");

endmodule

[bench/tb_pcx_rle_bitplane_decoder.sv]
// ----------------------------------------------------------------------------
// tb_pcx_rle_bitplane_decoder
// self-checking bench for the pcx run-length bitplane decoder
// ----------------------------------------------------------------------------
// compressed bytes are fed through the push side from a queue, decoded bytes
// are popped and compared field by field with a local decoder model. the run
// steps through several register settings, from clamped extremes to short
// padded lines and a full 4096-byte line, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_pcx_rle_bitplane_decoder;
  import pcxrle_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic [7:0]            code_byte = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            pixel_bits;
  logic                  row_end;
  logic                  image_end;
  logic                  last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pcx_rle_bitplane_decoder DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .code_byte(code_byte),
    .full(full),
    .empty(empty),
    .pop(pop),
    .pixel_bits(pixel_bits),
    .row_end(row_end),
    .image_end(image_end),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  logic [7:0] code_q[$];
  res_t       pixel_q[$];

  // decoder model state and registers
  logic                  run_armed = 1'b0;
  logic [RUN_W-1:0]      run_len = '0;
  logic [11:0]           col = '0;
  logic [15:0]           row = '0;
  logic [LINE_REG_W-1:0] line_reg = RST_LINE_BYTES;
  logic [LINE_REG_W-1:0] kept_reg = RST_KEPT_BYTES;
  logic [ROWS_REG_W-1:0] rows_reg = RST_IMAGE_ROWS;

  int  send_idle = 0;
  int  recv_idle = 0;
  bit  byte_sent = 1'b0;
  int  cycle_count = 0;
  int  n_errors = 0;
  int  n_codes = 0;
  int  n_pixels = 0;
  int  n_rows = 0;
  int  n_images = 0;
  int  n_settings = 1;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void queue_code(input logic [7:0] b);
    code_q = {code_q, b};
  endfunction

  function automatic void queue_pixel(input res_t r);
    pixel_q = {pixel_q, r};
  endfunction

  // expands one compressed byte into the decoded bytes it releases
  task automatic decode_byte(input logic [7:0] b);
    int   reps;
    int   eff_line;
    int   eff_kept;
    int   eff_rows;
    int   pos;
    bit   have_held;
    res_t held;
    res_t r;
    have_held = 1'b0;
    held = '0;
    if (run_armed) begin
      reps = int'(run_len);
      run_armed = 1'b0;
      run_len = '0;
    end else if (b[7:6] == HDR_TAG) begin
      run_len = b[RUN_W-1:0];
      run_armed = 1'b1;
      return;
    end else begin
      reps = 1;
    end
    for (int i = 0; i < reps; i++) begin
      eff_line = clamp(int'(line_reg), 1, DEF_MAX_LINE_BYTES);
      eff_kept = clamp(int'(kept_reg), 1, eff_line);
      eff_rows = clamp(int'(rows_reg), 1, DEF_MAX_ROWS);
      pos = int'(col);
      r.pixel_bits = b;
      r.row_end = (pos + 1 == eff_kept);
      r.image_end = r.row_end && (int'(row) + 1 >= eff_rows);
      r.last = 1'b0;
      if (pos < eff_kept) begin
        if (have_held) queue_pixel(held);
        held = r;
        have_held = 1'b1;
      end
      if (pos + 1 >= eff_line) begin
        col = '0;
        row = (int'(row) + 1 >= eff_rows) ? '0 : row + 16'd1;
      end else begin
        col = col + 12'd1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      queue_pixel(held);
    end
  endtask

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    n_errors++;
    $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
  endtask

  // input driver: holds each byte until its transfer
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || byte_sent) begin
      byte_sent = 1'b0;
      if (code_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        code_byte <= code_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor: models each transferred byte, checks each popped result
  always @(posedge clk) begin
    res_t want;
    res_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("status: fail");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        byte_sent = 1'b1;
        n_codes++;
        decode_byte(code_byte);
      end
      if (pop && !empty) begin
        got = {pixel_bits, row_end, image_end, last};
        if (pixel_q.size() == 0) begin
          n_errors++;
          $display("%0t unexpected result expected none actual %h", $time, got);
        end else begin
          want = pixel_q.pop_front();
          n_pixels++;
          if (got.row_end === 1'b1) n_rows++;
          if (got.image_end === 1'b1) n_images++;
          if (got.pixel_bits !== want.pixel_bits)
            report("pixel_bits", want.pixel_bits, got.pixel_bits);
          if (got.row_end !== want.row_end)
            report("row_end", 8'(want.row_end), 8'(got.row_end));
          if (got.image_end !== want.image_end)
            report("image_end", 8'(want.image_end), 8'(got.image_end));
          if (got.last !== want.last)
            report("last", 8'(want.last), 8'(got.last));
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_BYTES: line_reg = data[LINE_REG_W-1:0];
      REG_KEPT_BYTES: kept_reg = data[LINE_REG_W-1:0];
      REG_IMAGE_ROWS: rows_reg = data[ROWS_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_image(input int lines, input int kept, input int rows);
    write_reg(REG_LINE_BYTES, CFG_DATA_W'(lines));
    write_reg(REG_KEPT_BYTES, CFG_DATA_W'(kept));
    write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(rows));
    n_settings++;
  endtask

  task automatic add_run(input int len, input logic [7:0] value);
    queue_code({HDR_TAG, RUN_W'(len)});
    queue_code(value);
  endtask

  // mostly literals and well-formed runs, some arbitrary bytes
  task automatic add_random(input int n, input int max_run);
    int pick;
    int len;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_code(8'($urandom_range(0, 191)));
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 1) * 63;
        else len = $urandom_range(1, max_run);
        add_run(len, 8'($urandom_range(0, 255)));
      end else begin
        queue_code(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    while (code_q.size() != 0 || push || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 16;
    recv_idle = 76;

    // reset defaults: literals, empty run, longest run, header-like values
    queue_code(8'h00);
    queue_code(8'hBF);
    queue_code(8'h7F);
    queue_code(8'h80);
    queue_code(8'h01);
    add_run(0, 8'h12);
    add_run(63, {HDR_TAG, 6'h05});
    add_run(1, 8'hFF);
    add_run(2, {HDR_TAG, 6'h00});
    add_run(10, 8'hAA);
    add_random(8, 8);
    drain();

    set_image(1, 1, 1);
    add_random(10, 4);
    drain();

    // zero registers, plus an all-ones write to an unused index
    set_image(0, 0, 0);
    write_reg(REG_SPARE, 17'h1FFFF);
    add_random(6, 6);
    drain();

    send_idle = 76;
    recv_idle = 16;

    set_image(7, 3, 5);
    add_random(10, 12);
    drain();

    // oversized registers clamp to a 4096-byte line; cross one row end
    set_image(17'h1FFFF, 17'h1FFF, 17'h1FFFF);
    for (int i = 0; i < 66; i++) add_run(63, 8'($urandom_range(0, 255)));
    drain();

    set_image(16, 20, 17'h10000);
    add_random(10, 40);
    drain();

    send_idle = 0;
    recv_idle = 0;

    set_image(5, 2, 3);
    add_random(10, 20);
    drain();

    set_image(4096, 1, 2);
    add_random(6, 63);
    drain();

    $display("%0d code bytes transferred over %0d register settings", n_codes, n_settings);
    $display("%0d decoded bytes checked, %0d row ends, %0d image ends",
             n_pixels, n_rows, n_images);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pcxrle_pkg.sv
sv/pcxrle_fifo.sv
sv/pcxrle_front.sv
sv/pcxrle_back.sv
sv/pcx_rle_bitplane_decoder.sv
bench/tb_pcx_rle_bitplane_decoder.sv
